>>> rtl/assert_macros.svh
// Assertion macros used by the pointer unit of the two-queue store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TQS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tqs_pkg.sv
package tqs_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    OP_ENQ_A  = 3'd0,
    OP_ENQ_B  = 3'd1,
    OP_DEQ_A  = 3'd2,
    OP_DEQ_B  = 3'd3,
    OP_LIST_A = 3'd4,
    OP_LIST_B = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // Pointer updates requested by the sequencer.
  typedef struct packed {
    logic enq_a;
    logic enq_b;
    logic deq_a;
    logic deq_b;
  } ptr_cmd_t;

  // Queue status reported by the pointer unit.
  typedef struct packed {
    logic a_valid;
    logic b_valid;
    logic full;
  } ptr_flags_t;

endpackage

>>> rtl/tqs_ram.sv
module tqs_ram #(
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [$clog2(DEPTH)-1:0]             waddr,
  input  logic [tqs_pkg::DATA_W-1:0]           wdata,
  input  logic                                 re,
  input  logic [$clog2(DEPTH)-1:0]             raddr,
  output logic [tqs_pkg::DATA_W-1:0]           rdata
);
  import tqs_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while no new read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/tqs_ptrs.sv
`include "assert_macros.svh"

module tqs_ptrs #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tqs_pkg::ptr_cmd_t         cmd,
  output tqs_pkg::ptr_flags_t       flags,
  output logic [$clog2(DEPTH)-1:0]  a_head,
  output logic [$clog2(DEPTH)-1:0]  a_tail,
  output logic [$clog2(DEPTH)-1:0]  b_head,
  output logic [$clog2(DEPTH)-1:0]  b_tail,
  output logic [$clog2(DEPTH)-1:0]  enq_a_addr,
  output logic [$clog2(DEPTH)-1:0]  enq_b_addr
);
  import tqs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] TOP_IDX = AW'(DEPTH - 1);

  logic [AW-1:0] a_head_r, a_head_nxt, a_tail_r, a_tail_nxt;
  logic [AW-1:0] b_head_r, b_head_nxt, b_tail_r, b_tail_nxt;
  logic          a_valid_r, a_valid_nxt, b_valid_r, b_valid_nxt;
  logic [AW:0]   a_next, b_low;

  // The store is full when the slot just above A's tail is B's tail.
  assign a_next = a_valid_r ? ({1'b0, a_tail_r} + 1'b1) : '0;
  assign b_low  = b_valid_r ? {1'b0, b_tail_r} : DEPTH_W;

  assign flags.a_valid = a_valid_r;
  assign flags.b_valid = b_valid_r;
  assign flags.full    = (a_next == b_low);

  assign enq_a_addr = a_next[AW-1:0];
  assign enq_b_addr = b_valid_r ? (b_tail_r - 1'b1) : TOP_IDX;

  assign a_head = a_head_r;
  assign a_tail = a_tail_r;
  assign b_head = b_head_r;
  assign b_tail = b_tail_r;

  always_comb begin
    a_head_nxt  = a_head_r;
    a_tail_nxt  = a_tail_r;
    a_valid_nxt = a_valid_r;
    b_head_nxt  = b_head_r;
    b_tail_nxt  = b_tail_r;
    b_valid_nxt = b_valid_r;
    if (cmd.enq_a) begin
      a_tail_nxt  = enq_a_addr;
      a_valid_nxt = 1'b1;
      if (!a_valid_r) begin
        a_head_nxt = '0;
      end
    end
    if (cmd.enq_b) begin
      b_tail_nxt  = enq_b_addr;
      b_valid_nxt = 1'b1;
      if (!b_valid_r) begin
        b_head_nxt = TOP_IDX;
      end
    end
    // Removing the last element is the only point where space comes back.
    if (cmd.deq_a) begin
      if (a_head_r == a_tail_r) begin
        a_valid_nxt = 1'b0;
        a_head_nxt  = '0;
        a_tail_nxt  = '0;
      end else begin
        a_head_nxt = a_head_r + 1'b1;
      end
    end
    if (cmd.deq_b) begin
      if (b_head_r == b_tail_r) begin
        b_valid_nxt = 1'b0;
        b_head_nxt  = '0;
        b_tail_nxt  = '0;
      end else begin
        b_head_nxt = b_head_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_head_r  <= '0;
      a_tail_r  <= '0;
      a_valid_r <= 1'b0;
      b_head_r  <= '0;
      b_tail_r  <= '0;
      b_valid_r <= 1'b0;
    end else begin
      a_head_r  <= a_head_nxt;
      a_tail_r  <= a_tail_nxt;
      a_valid_r <= a_valid_nxt;
      b_head_r  <= b_head_nxt;
      b_tail_r  <= b_tail_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  `TQS_ASSERT_IMPL(a_order_chk, clk, rst_n, a_valid_r, a_head_r <= a_tail_r, "A head past tail")
  `TQS_ASSERT_IMPL(b_order_chk, clk, rst_n, b_valid_r, b_tail_r <= b_head_r, "B head past tail")
  `TQS_ASSERT_IMPL(no_cross_chk, clk, rst_n, a_valid_r && b_valid_r, a_tail_r < b_tail_r, "queues overlap")
  `TQS_ASSERT_NEXT(a_drain_chk, clk, rst_n, cmd.deq_a && (a_head_r == a_tail_r), !a_valid_r, "A not empty after last dequeue")

endmodule

>>> rtl/two_queues_shared_store.sv
// Two FIFO queues, A and B, kept in one synchronous store of DEPTH words.
// A fills the store from the bottom, B from the top; an enqueue overflows
// when the two tails meet, and slots are reclaimed only when a queue empties.
// Requests arrive on in_valid/in_ready carrying in_op and in_value; results
// leave on out_valid/out_ready as out_status, out_data and out_last.
// Every request yields one result, except a list of a non-empty queue, which
// yields one result per element, oldest first, with out_last on the final one.
// Unused op codes give no result.
// Enqueue and error results are registered at acceptance and show in the next
// cycle. A dequeue or list reads the store, whose read port is registered, so
// its first result passes the read register, then the output register; a list
// streams one element per cycle from that read port while out_ready is high.
// A new request is taken once the previous one has produced all its results,
// in a cycle in which the output register is empty or freed by out_ready.
// When the receiver stalls, the output register holds its result and the
// store reads pause; nothing is lost or repeated.
// Synchronous reset empties both queues; store contents are not cleared.
module two_queues_shared_store #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_op,
  input  logic signed [tqs_pkg::DATA_W-1:0]   in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic signed [tqs_pkg::DATA_W-1:0]   out_data,
  output logic                                out_last
);
  import tqs_pkg::*;

  localparam int AW = $clog2(DEPTH);

  state_t        state_r, state_nxt;
  ptr_cmd_t      cmd;
  ptr_flags_t    flags;
  logic [AW-1:0] a_head, a_tail, b_head, b_tail, enq_a_addr, enq_b_addr;

  logic              accept, out_free, go_read;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Read sequencer: next address, final address, direction, last flag.
  logic [AW-1:0] idx_r, idx_nxt, end_r, end_nxt;
  logic          down_r, down_nxt, last_r, last_nxt;

  logic              out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;

  tqs_ptrs #(.DEPTH(DEPTH)) u_ptrs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .flags      (flags),
    .a_head     (a_head),
    .a_tail     (a_tail),
    .b_head     (b_head),
    .b_tail     (b_tail),
    .enq_a_addr (enq_a_addr),
    .enq_b_addr (enq_b_addr)
  );

  tqs_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Decode of the accepted request.
  always_comb begin
    cmd     = '0;
    go_read = 1'b0;
    if (accept) begin
      case (in_op)
        OP_ENQ_A:  cmd.enq_a = !flags.full;
        OP_ENQ_B:  cmd.enq_b = !flags.full;
        OP_DEQ_A:  begin
          cmd.deq_a = flags.a_valid;
          go_read   = flags.a_valid;
        end
        OP_DEQ_B:  begin
          cmd.deq_b = flags.b_valid;
          go_read   = flags.b_valid;
        end
        OP_LIST_A: go_read = flags.a_valid;
        OP_LIST_B: go_read = flags.b_valid;
        default:   ;
      endcase
    end
  end

  assign ram_we    = cmd.enq_a || cmd.enq_b;
  assign ram_waddr = cmd.enq_a ? enq_a_addr : enq_b_addr;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (go_read) state_nxt = S_READ;
      S_READ:  if (out_free && last_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, store reads and the result register.
  always_comb begin
    in_ready       = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = idx_r;
    idx_nxt        = idx_r;
    end_nxt        = end_r;
    down_nxt       = down_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      S_IDLE: begin
        in_ready = out_free;
        if (accept) begin
          case (in_op)
            OP_ENQ_A, OP_ENQ_B: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = flags.full ? STAT_OVERFLOW : STAT_OK;
              out_data_nxt   = '0;
              out_last_nxt   = 1'b1;
            end
            OP_DEQ_A, OP_DEQ_B, OP_LIST_A, OP_LIST_B: begin
              // A list starts at the head and walks toward the tail; a
              // dequeue is a list that stops after the head.
              down_nxt = (in_op == OP_DEQ_B) || (in_op == OP_LIST_B);
              if (down_nxt) begin
                ram_raddr = b_head;
                end_nxt   = b_tail;
                idx_nxt   = b_head - 1'b1;
              end else begin
                ram_raddr = a_head;
                end_nxt   = a_tail;
                idx_nxt   = a_head + 1'b1;
              end
              ram_re   = go_read;
              last_nxt = (in_op == OP_DEQ_A) || (in_op == OP_DEQ_B) ||
                         (ram_raddr == end_nxt);
              if (!go_read) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ((in_op == OP_DEQ_A) || (in_op == OP_DEQ_B)) ?
                                 STAT_UNDERFLOW : STAT_EMPTY;
                out_data_nxt   = '0;
                out_last_nxt   = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_data_nxt   = ram_rdata;
          out_last_nxt   = last_r;
          if (!last_r) begin
            ram_re   = 1'b1;
            last_nxt = (idx_r == end_r);
            idx_nxt  = down_r ? (idx_r - 1'b1) : (idx_r + 1'b1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    end_r        <= end_nxt;
    down_r       <= down_nxt;
    last_r       <= last_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

endmodule

>>> sim/tb.sv
module tb;
  import tqs_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int RANDOM_REQUESTS = 250;
  localparam int IDLE_PERCENT = 31;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    status_t     status;
    logic [31:0] data;
    logic        last;
  } result_t;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] value;
    int          reps;
    bit          typed;
    status_t     exp_status;
    logic [31:0] exp_data;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_op = OP_ENQ_A;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_data;
  logic               out_last;

  // Shadow copy of the two queues.
  logic [31:0] shadow_slots [DEPTH];
  int          a_head = 0, a_tail = 0, b_head = 0, b_tail = 0;
  bit          a_live = 1'b0, b_live = 1'b0;

  result_t pending_results [$];
  result_t step_results [$];

  bit steady = 1'b0;
  int mismatches = 0;
  int results_seen = 0;
  int enq_count = 0, deq_count = 0, list_count = 0, spare_count = 0;
  int overflows = 0, underflows = 0, empty_lists = 0;

  // The fill row writes 14 words between the two first entries, so the store ends up full.
  plan_row_t directed_plan [16] = '{
    '{OP_DEQ_A,   32'h0000_0000,  1, 1'b1, STAT_UNDERFLOW, 32'h0},
    '{OP_DEQ_B,   32'h0000_0000,  1, 1'b1, STAT_UNDERFLOW, 32'h0},
    '{OP_LIST_A,  32'h0000_0000,  1, 1'b1, STAT_EMPTY,     32'h0},
    '{OP_LIST_B,  32'h0000_0000,  1, 1'b1, STAT_EMPTY,     32'h0},
    '{OP_SPARE_7, 32'hFFFF_FFFF,  1, 1'b0, STAT_OK,        32'h0},
    '{OP_ENQ_A,   32'h7FFF_FFFF,  1, 1'b1, STAT_OK,        32'h0},
    '{OP_ENQ_B,   32'h8000_0000,  1, 1'b1, STAT_OK,        32'h0},
    '{OP_ENQ_A,   32'hFFFF_FFF4, 14, 1'b0, STAT_OK,        32'h0},
    '{OP_ENQ_B,   32'h0000_0000,  1, 1'b1, STAT_OVERFLOW,  32'h0},
    '{OP_ENQ_A,   32'h0000_0000,  1, 1'b1, STAT_OVERFLOW,  32'h0},
    '{OP_LIST_A,  32'h0000_0000,  1, 1'b0, STAT_OK,        32'h0},
    '{OP_LIST_B,  32'h0000_0000,  1, 1'b0, STAT_OK,        32'h0},
    '{OP_DEQ_A,   32'h0000_0000,  1, 1'b1, STAT_OK,        32'h7FFF_FFFF},
    '{OP_ENQ_A,   32'h2468_ACE0,  1, 1'b1, STAT_OVERFLOW,  32'h0},
    '{OP_DEQ_B,   32'h0000_0000,  1, 1'b1, STAT_OK,        32'h8000_0000},
    '{OP_ENQ_B,   32'h1357_9BDF,  1, 1'b1, STAT_OK,        32'h0}
  };

  two_queues_shared_store #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_status(out_status),
    .out_data  (out_data),
    .out_last  (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_result(status_t status, logic [31:0] data, logic last);
    step_results.push_back('{status, data, last});
  endfunction

  // A's next free slot against B's lowest occupied slot.
  function automatic bit store_full();
    int a_next;
    int b_low;
    a_next = a_live ? a_tail + 1 : 0;
    b_low = b_live ? b_tail : DEPTH;
    return a_next == b_low;
  endfunction

  function automatic void predict_queue_op(logic [2:0] op, logic [31:0] value);
    int i;
    step_results.delete();
    case (op)
      OP_ENQ_A, OP_ENQ_B: begin
        enq_count++;
        if (store_full()) begin
          overflows++;
          add_result(STAT_OVERFLOW, 32'h0, 1'b1);
        end else begin
          if (op == OP_ENQ_A) begin
            if (a_live) begin
              a_tail++;
            end else begin
              a_head = 0;
              a_tail = 0;
              a_live = 1'b1;
            end
            shadow_slots[a_tail] = value;
          end else begin
            if (b_live) begin
              b_tail--;
            end else begin
              b_head = DEPTH - 1;
              b_tail = DEPTH - 1;
              b_live = 1'b1;
            end
            shadow_slots[b_tail] = value;
          end
          add_result(STAT_OK, 32'h0, 1'b1);
        end
      end
      OP_DEQ_A: begin
        deq_count++;
        if (!a_live) begin
          underflows++;
          add_result(STAT_UNDERFLOW, 32'h0, 1'b1);
        end else begin
          add_result(STAT_OK, shadow_slots[a_head], 1'b1);
          // Slots are reclaimed only when the queue runs empty.
          if (a_head == a_tail) begin
            a_live = 1'b0;
            a_head = 0;
            a_tail = 0;
          end else begin
            a_head++;
          end
        end
      end
      OP_DEQ_B: begin
        deq_count++;
        if (!b_live) begin
          underflows++;
          add_result(STAT_UNDERFLOW, 32'h0, 1'b1);
        end else begin
          add_result(STAT_OK, shadow_slots[b_head], 1'b1);
          if (b_head == b_tail) begin
            b_live = 1'b0;
            b_head = 0;
            b_tail = 0;
          end else begin
            b_head--;
          end
        end
      end
      OP_LIST_A: begin
        list_count++;
        if (!a_live) begin
          empty_lists++;
          add_result(STAT_EMPTY, 32'h0, 1'b1);
        end else begin
          for (i = a_head; i <= a_tail; i++) begin
            add_result(STAT_OK, shadow_slots[i], i == a_tail);
          end
        end
      end
      OP_LIST_B: begin
        list_count++;
        if (!b_live) begin
          empty_lists++;
          add_result(STAT_EMPTY, 32'h0, 1'b1);
        end else begin
          for (i = b_head; i >= b_tail; i--) begin
            add_result(STAT_OK, shadow_slots[i], i == b_tail);
          end
        end
      end
      default: begin
        spare_count++;
      end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [2:0] op, input logic [31:0] value, input bit typed,
                              input status_t exp_status, input logic [31:0] exp_data);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_value <= value;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_queue_op(op, value);
    if (typed) begin
      pending_results.push_back('{exp_status, exp_data, 1'b1});
    end else begin
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    end
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected result status %0d data %h last %0d", $time,
                   out_status, out_data, out_last);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_data !== want.data || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: expected status %0d data %h last %0d, got status %0d data %h last %0d",
                     $time, want.status, want.data, want.last, out_status, out_data, out_last);
          end
        end
      end
    end
  end

  initial begin
    int rnd_requests;
    int segment_left;
    int fill_pct;
    int side_pct;
    int pick;
    bit paused;
    logic [2:0] op;
    logic [31:0] value;

    rnd_requests = 0;
    segment_left = 0;
    fill_pct = 50;
    side_pct = 50;
    paused = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_plan[r]) begin
      for (int n = 0; n < directed_plan[r].reps; n++) begin
        send_request(directed_plan[r].op, directed_plan[r].value + n, directed_plan[r].typed,
                     directed_plan[r].exp_status, directed_plan[r].exp_data);
      end
    end
    wait_for_drain();

    // Each segment leans at random toward filling or draining so that both the full store
    // and the reclaim on a queue running empty come up many times.
    while (rnd_requests < RANDOM_REQUESTS) begin
      if (segment_left == 0) begin
        segment_left = $urandom_range(10, 30);
        fill_pct = ($urandom_range(0, 1) != 0) ? 75 : 30;
        side_pct = $urandom_range(10, 90);
      end
      segment_left--;
      steady = (rnd_requests >= 40 && rnd_requests < 110);
      if (rnd_requests == 150 && !paused) begin
        paused = 1'b1;
        wait_for_drain();
      end

      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        op = ($urandom_range(0, 1) != 0) ? OP_SPARE_7 : OP_SPARE_6;
      end else if (pick < 15) begin
        op = ($urandom_range(0, 99) < side_pct) ? OP_LIST_A : OP_LIST_B;
      end else if ($urandom_range(0, 99) < fill_pct) begin
        op = ($urandom_range(0, 99) < side_pct) ? OP_ENQ_A : OP_ENQ_B;
      end else begin
        op = ($urandom_range(0, 99) < side_pct) ? OP_DEQ_A : OP_DEQ_B;
      end

      case ($urandom_range(0, 7))
        0: value = 32'h7FFF_FFFF;
        1: value = 32'h8000_0000;
        default: value = $urandom;
      endcase

      send_request(op, value, 1'b0, STAT_OK, 32'h0);
      if (op != OP_SPARE_6 && op != OP_SPARE_7) rnd_requests++;
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d enqueues, %0d dequeues, %0d lists and %0d unused ops; %0d results checked.",
             enq_count, deq_count, list_count, spare_count, results_seen);
    $display("Hit %0d overflows, %0d underflows and %0d lists of an empty queue.",
             overflows, underflows, empty_lists);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results still pending.", pending_results.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/tqs_pkg.sv
rtl/tqs_ram.sv
rtl/tqs_ptrs.sv
rtl/two_queues_shared_store.sv
sim/tb.sv
